FILE: sv/rmq_pkg.sv
// Package for the rotation matrix to quaternion pipeline.
// Holds the sample format, derived widths, branch codes, sideband types and the output clamp.
// Has no dependencies.
`default_nettype none
package rmq_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = SAMPLE_WIDTH - 2;
    localparam int TW           = SAMPLE_WIDTH + 3;
    localparam int DW           = SAMPLE_WIDTH + 1;
    localparam int RAD_W        = 2 * SAMPLE_WIDTH;
    localparam int SQ_W         = RAD_W + 1;
    localparam int NUM_W        = 2 * SAMPLE_WIDTH;
    localparam int DEN_W        = SAMPLE_WIDTH + 1;
    localparam int REM_W        = NUM_W + 1;
    localparam int SQ_N         = SAMPLE_WIDTH;
    localparam int DIV_N        = SAMPLE_WIDTH;
    localparam int LATENCY      = SQ_N + DIV_N + 3;

    typedef enum logic [1:0] {
        BR_X = 2'd0,
        BR_Y = 2'd1,
        BR_Z = 2'd2,
        BR_W = 2'd3
    } t_branch;

    typedef struct packed {
        t_branch                  branch;
        logic signed [DW-1:0]     d0;
        logic signed [DW-1:0]     d1;
        logic signed [DW-1:0]     d2;
    } t_side;

    typedef struct packed {
        t_branch                      branch;
        logic [2:0]                   neg;
        logic                         azero;
        logic [SAMPLE_WIDTH-1:0]      big;
    } t_dside;

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_quot(
        input logic [SAMPLE_WIDTH-1:0] q,
        input logic                    ovf,
        input logic                    neg,
        input logic                    azero
    );
        logic [SAMPLE_WIDTH:0]         qe;
        logic signed [SAMPLE_WIDTH-1:0] r;
        qe = {1'b0, q};
        if (azero) begin
            r = '0;
        end else if (!neg) begin
            if (ovf || q[SAMPLE_WIDTH-1]) begin
                r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            end else begin
                r = q;
            end
        end else begin
            if (ovf || (qe > ((SAMPLE_WIDTH+1)'(1) << (SAMPLE_WIDTH-1)))) begin
                r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            end else begin
                r = SAMPLE_WIDTH'(-qe);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/rmq_prep.sv
// Entry stage: trace, branch choice, radicand and off-diagonal sums and differences, one register stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_prep import rmq_pkg::*; (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    input  wire signed [SAMPLE_WIDTH-1:0] i_m00,
    input  wire signed [SAMPLE_WIDTH-1:0] i_m01,
    input  wire signed [SAMPLE_WIDTH-1:0] i_m02,
    input  wire signed [SAMPLE_WIDTH-1:0] i_m10,
    input  wire signed [SAMPLE_WIDTH-1:0] i_m11,
    input  wire signed [SAMPLE_WIDTH-1:0] i_m12,
    input  wire signed [SAMPLE_WIDTH-1:0] i_m20,
    input  wire signed [SAMPLE_WIDTH-1:0] i_m21,
    input  wire signed [SAMPLE_WIDTH-1:0] i_m22,
    output logic                          o_valid,
    output logic [RAD_W-1:0]              o_rad,
    output t_side                         o_side
);

    localparam logic signed [TW-1:0] ONE = TW'(1) <<< FRAC_BITS;

    logic signed [TW-1:0] e00, e11, e22, trace, t;
    logic [RAD_W-1:0]     n_rad;
    t_side                n_side;
    logic                 r_valid;
    logic [RAD_W-1:0]     r_rad;
    t_side                r_side;

    always_comb begin
        e00   = TW'(i_m00);
        e11   = TW'(i_m11);
        e22   = TW'(i_m22);
        trace = e00 + e11 + e22;
        if (trace > 0) begin
            n_side.branch = BR_W;
            t             = ONE + trace;
            n_side.d0     = DW'(i_m12) - DW'(i_m21);
            n_side.d1     = DW'(i_m20) - DW'(i_m02);
            n_side.d2     = DW'(i_m01) - DW'(i_m10);
        end else if ((i_m00 > i_m11) && (i_m00 > i_m22)) begin
            n_side.branch = BR_X;
            t             = ONE + e00 - e11 - e22;
            n_side.d0     = DW'(i_m12) - DW'(i_m21);
            n_side.d1     = DW'(i_m01) + DW'(i_m10);
            n_side.d2     = DW'(i_m02) + DW'(i_m20);
        end else if (i_m11 > i_m22) begin
            n_side.branch = BR_Y;
            t             = ONE + e11 - e00 - e22;
            n_side.d0     = DW'(i_m20) - DW'(i_m02);
            n_side.d1     = DW'(i_m01) + DW'(i_m10);
            n_side.d2     = DW'(i_m12) + DW'(i_m21);
        end else begin
            n_side.branch = BR_Z;
            t             = ONE + e22 - e00 - e11;
            n_side.d0     = DW'(i_m01) - DW'(i_m10);
            n_side.d1     = DW'(i_m02) + DW'(i_m20);
            n_side.d2     = DW'(i_m12) + DW'(i_m21);
        end
        if (t[TW-1]) begin
            n_rad = '0;
        end else begin
            n_rad = RAD_W'(unsigned'(t)) << FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rad  <= n_rad;
        r_side <= n_side;
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_side  = r_side;

endmodule
`default_nettype wire

FILE: sv/rmq_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries the branch sideband alongside. Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire [RAD_W-1:0]         i_rad,
    input  t_side                   i_side,
    output logic                    o_valid,
    output logic [SAMPLE_WIDTH-1:0] o_root,
    output t_side                   o_side
);

    logic            w_valid [0:SQ_N];
    logic [SQ_W-1:0] w_x     [0:SQ_N];
    logic [SQ_W-1:0] w_res   [0:SQ_N];
    t_side           w_side  [0:SQ_N];

    assign w_valid[0] = i_valid;
    assign w_x[0]     = SQ_W'(i_rad);
    assign w_res[0]   = '0;
    assign w_side[0]  = i_side;

    for (genvar k = 0; k < SQ_N; k++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_N - 1 - k));
        logic [SQ_W-1:0] sum, n_x, n_res;
        logic            r_valid;
        logic [SQ_W-1:0] r_x, r_res;
        t_side           r_side;

        always_comb begin
            sum = w_res[k] + BIT;
            if (w_x[k] >= sum) begin
                n_x   = w_x[k] - sum;
                n_res = (w_res[k] >> 1) + BIT;
            end else begin
                n_x   = w_x[k];
                n_res = w_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= w_valid[k];
            end
            r_x    <= n_x;
            r_res  <= n_res;
            r_side <= w_side[k];
        end

        assign w_valid[k+1] = r_valid;
        assign w_x[k+1]     = r_x;
        assign w_res[k+1]   = r_res;
        assign w_side[k+1]  = r_side;
    end

    assign o_valid = w_valid[SQ_N];
    assign o_root  = w_res[SQ_N][SAMPLE_WIDTH-1:0];
    assign o_side  = w_side[SQ_N];

endmodule
`default_nettype wire

FILE: sv/rmq_div.sv
// Pipelined restoring divider, one quotient bit per register stage, with overflow flag.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div import rmq_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire [NUM_W-1:0]         i_num,
    input  wire [DEN_W-1:0]         i_den,
    output logic                    o_valid,
    output logic [SAMPLE_WIDTH-1:0] o_quot,
    output logic                    o_ovf
);

    logic                    w_valid [0:DIV_N];
    logic [REM_W-1:0]        w_rem   [0:DIV_N];
    logic [DEN_W-1:0]        w_den   [0:DIV_N];
    logic [SAMPLE_WIDTH-1:0] w_quot  [0:DIV_N];
    logic                    w_ovf   [0:DIV_N];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = REM_W'(i_num);
    assign w_den[0]   = i_den;
    assign w_quot[0]  = '0;
    assign w_ovf[0]   = REM_W'(i_num) >= (REM_W'(i_den) << DIV_N);

    for (genvar k = 0; k < DIV_N; k++) begin : g_stage
        localparam int J = DIV_N - 1 - k;
        logic [REM_W-1:0]        sh, n_rem;
        logic [SAMPLE_WIDTH-1:0] n_quot;
        logic                    r_valid, r_ovf;
        logic [REM_W-1:0]        r_rem;
        logic [DEN_W-1:0]        r_den;
        logic [SAMPLE_WIDTH-1:0] r_quot;

        always_comb begin
            sh     = REM_W'(w_den[k]) << J;
            n_rem  = w_rem[k];
            n_quot = w_quot[k];
            if (w_rem[k] >= sh) begin
                n_rem     = w_rem[k] - sh;
                n_quot[J] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else begin
                r_valid <= w_valid[k];
            end
            r_rem  <= n_rem;
            r_den  <= w_den[k];
            r_quot <= n_quot;
            r_ovf  <= w_ovf[k];
        end

        assign w_valid[k+1] = r_valid;
        assign w_rem[k+1]   = r_rem;
        assign w_den[k+1]   = r_den;
        assign w_quot[k+1]  = r_quot;
        assign w_ovf[k+1]   = r_ovf;
    end

    assign o_valid = w_valid[DIV_N];
    assign o_quot  = w_quot[DIV_N];
    assign o_ovf   = w_ovf[DIV_N];

endmodule
`default_nettype wire

FILE: sv/rotation_matrix_to_quaternion.sv
// Pipeline from the accepted start beat to the o_valid strobe: one entry stage,
// 16 square-root stages, one setup stage, 16 divider stages, one output stage.
// Throughput: one beat per cycle; busy is always low and the receiver cannot stall.
// Reset: synchronous active-low i_rst_n clears all valid bits; payload is not reset.
// Depends on rmq_pkg, rmq_prep, rmq_sqrt and rmq_div.
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_m00,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_m01,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_m02,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_m10,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_m11,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_m12,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_m20,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_m21,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_m22,
    output logic                           o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_z,
    output logic signed [SAMPLE_WIDTH-1:0] o_quat_w
);

    logic                    p_valid;
    logic [RAD_W-1:0]        p_rad;
    t_side                   p_side;
    logic                    s_valid;
    logic [SAMPLE_WIDTH-1:0] s_root;
    t_side                   s_side;

    assign busy = 1'b0;

    rmq_prep u_prep (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start && !busy),
        .i_m00(i_m00), .i_m01(i_m01), .i_m02(i_m02),
        .i_m10(i_m10), .i_m11(i_m11), .i_m12(i_m12),
        .i_m20(i_m20), .i_m21(i_m21), .i_m22(i_m22),
        .o_valid(p_valid), .o_rad(p_rad), .o_side(p_side)
    );

    rmq_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(p_valid), .i_rad(p_rad),
        .i_side(p_side), .o_valid(s_valid), .o_root(s_root), .o_side(s_side)
    );

    logic signed [DW-1:0]  d     [0:2];
    logic [DW-1:0]         mag   [0:2];
    logic [NUM_W-1:0]      n_num [0:2];
    t_dside                n_ds;
    logic                  r_sv;
    logic [NUM_W-1:0]      r_num [0:2];
    logic [DEN_W-1:0]      r_den;
    t_dside                r_ds;

    always_comb begin
        d[0] = s_side.d0;
        d[1] = s_side.d1;
        d[2] = s_side.d2;
        for (int i = 0; i < 3; i++) begin
            mag[i]      = d[i][DW-1] ? DW'(-d[i]) : DW'(d[i]);
            n_num[i]    = (NUM_W'(mag[i]) << FRAC_BITS) + NUM_W'(s_root);
            n_ds.neg[i] = d[i][DW-1];
        end
        n_ds.branch = s_side.branch;
        n_ds.azero  = (s_root == '0);
        n_ds.big    = SAMPLE_WIDTH'(((SAMPLE_WIDTH+1)'(s_root) + 1'b1) >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
        end else begin
            r_sv <= s_valid;
        end
        r_num <= n_num;
        r_den <= {s_root, 1'b0};
        r_ds  <= n_ds;
    end

    logic                    q_valid [0:2];
    logic [SAMPLE_WIDTH-1:0] q_quot  [0:2];
    logic                    q_ovf   [0:2];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        rmq_div u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_sv), .i_num(r_num[l]),
            .i_den(r_den), .o_valid(q_valid[l]), .o_quot(q_quot[l]), .o_ovf(q_ovf[l])
        );
    end

    t_dside r_dly [0:DIV_N-1];

    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_ds;
        for (int i = 1; i < DIV_N; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    t_dside                         fd;
    logic signed [SAMPLE_WIDTH-1:0] qv [0:2];
    logic signed [SAMPLE_WIDTH-1:0] n_x, n_y, n_z, n_w;
    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_x, r_y, r_z, r_w;

    always_comb begin
        fd = r_dly[DIV_N-1];
        for (int i = 0; i < 3; i++) begin
            qv[i] = sat_quot(q_quot[i], q_ovf[i], fd.neg[i], fd.azero);
        end
        unique case (fd.branch)
            BR_W: begin
                n_w = fd.big; n_x = qv[0]; n_y = qv[1]; n_z = qv[2];
            end
            BR_X: begin
                n_x = fd.big; n_w = qv[0]; n_y = qv[1]; n_z = qv[2];
            end
            BR_Y: begin
                n_y = fd.big; n_w = qv[0]; n_x = qv[1]; n_z = qv[2];
            end
            default: begin
                n_z = fd.big; n_w = qv[0]; n_x = qv[1]; n_y = qv[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= q_valid[0];
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        r_w <= n_w;
    end

    assign o_valid  = r_valid;
    assign o_quat_x = r_x;
    assign o_quat_y = r_y;
    assign o_quat_z = r_z;
    assign o_quat_w = r_w;

    a_lat_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid) else $error("start beat produced no result");

    a_lat_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##LATENCY !o_valid) else $error("result strobe without a start beat");

    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid[0] == q_valid[1]) && (q_valid[1] == q_valid[2]))
        else $error("divider lanes out of step");

endmodule
`default_nettype wire
